/* rtl/roc_pkg.sv */
// ----------------------------------------------------------------------------
// roc_pkg
// Shared widths and types for the ray / oriented box slab core.
// ----------------------------------------------------------------------------
package roc_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W  = 32;
  localparam int AXIS_W  = 16;
  localparam int REG_W   = 48;
  localparam int FRAC_SH = 16;
  localparam int HALF_SH = 14;
  localparam int PAR_EPS = 4;

  localparam int TOC_W = COORD_W + 1;
  localparam int E_W   = TOC_W + AXIS_W + 2;
  localparam int F_W   = COORD_W + AXIS_W + 2;
  localparam int NUM_W = E_W + 1;
  localparam int DEN_W = F_W;
  localparam int QW    = NUM_W + FRAC_SH;
  localparam int T_W   = QW + 1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_U = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_V = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 3'd4;

  localparam logic [REG_W-1:0] RST_CENTER = 48'h0;
  localparam logic [REG_W-1:0] RST_AXIS_U = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] RST_AXIS_V = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] RST_AXIS_W = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] RST_HALF   = 48'h0100_0100_0100;

  typedef struct packed {
    logic [REG_W-1:0]      center;
    logic [2:0][REG_W-1:0] axis;
    logic [REG_W-1:0]      half;
  } box_cfg_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    nq;
    logic [DEN_W-1:0] d;
  } div_t;

  typedef struct packed {
    logic [2:0] par;
    logic [2:0] pmiss;
    logic [2:0] neg1;
    logic [2:0] neg2;
  } side_t;

endpackage

/* rtl/ray_obb_slab_intersection_core.sv */
// ----------------------------------------------------------------------------
// ray_obb_slab_intersection_core
// Ray versus oriented box slab test, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Load the box through the cfg channel (cfg_ready is always high) while no
//   ray is in flight: 0 center, 1..3 axes u/v/w, 4 half lengths; other
//   indexes are ignored.
//   Issue a ray by raising start with the six in_ fields; busy stays low, so
//   one ray beat is taken every cycle.
//   Each result appears for one cycle, with
//   out_valid high. Results leave in issue order.
//   The divider chain holds 52 restoring divide cells per slab
//   bound, one quotient bit each, six chains in parallel; around it lie four
//   projection stages and three interval stages.
//   Throughput: one ray per cycle.
//   Reset clears the pipeline valid bits and restores the unit box at the
//   origin. There is no output back pressure.
// ----------------------------------------------------------------------------
module ray_obb_slab_intersection_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [roc_pkg::COORD_W-1:0] in_origin_x,
  input  logic signed [roc_pkg::COORD_W-1:0] in_origin_y,
  input  logic signed [roc_pkg::COORD_W-1:0] in_origin_z,
  input  logic signed [roc_pkg::COORD_W-1:0] in_dir_x,
  input  logic signed [roc_pkg::COORD_W-1:0] in_dir_y,
  input  logic signed [roc_pkg::COORD_W-1:0] in_dir_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [roc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [roc_pkg::REG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [roc_pkg::DIST_W-1:0]         out_t_enter,
  output logic [roc_pkg::DIST_W-1:0]         out_t_exit
);
  import roc_pkg::*;

  box_cfg_t cfg_r;
  logic acc;
  logic signed [COORD_W-1:0] org [3];
  logic signed [COORD_W-1:0] dir [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign org       = '{in_origin_x, in_origin_y, in_origin_z};
  assign dir       = '{in_dir_x, in_dir_y, in_dir_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center  <= RST_CENTER;
      cfg_r.axis[0] <= RST_AXIS_U;
      cfg_r.axis[1] <= RST_AXIS_V;
      cfg_r.axis[2] <= RST_AXIS_W;
      cfg_r.half    <= RST_HALF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER: cfg_r.center  <= cfg_data;
        REG_AXIS_U: cfg_r.axis[0] <= cfg_data;
        REG_AXIS_V: cfg_r.axis[1] <= cfg_data;
        REG_AXIS_W: cfg_r.axis[2] <= cfg_data;
        REG_HALF:   cfg_r.half    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic  p_vld;
  side_t p_side;
  div_t  chain [QW+1][6];

  roc_proj u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .org    (org),
    .dir    (dir),
    .cfg    (cfg_r),
    .vld    (p_vld),
    .div_o  (chain[0]),
    .side_o (p_side)
  );

  logic  v_r [QW];
  side_t s_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    for (genvar j = 0; j < 6; j++) begin : g_lane
      roc_div_cell u_cell (
        .clk  (clk),
        .din  (chain[s][j]),
        .dout (chain[s+1][j])
      );
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else        v_r[s] <= (s == 0) ? p_vld : v_r[(s == 0) ? 0 : s-1];
    end
    always_ff @(posedge clk) begin
      s_r[s] <= (s == 0) ? p_side : s_r[(s == 0) ? 0 : s-1];
    end
  end

  logic [QW-1:0] quo [6];
  for (genvar j = 0; j < 6; j++) begin : g_quo
    assign quo[j] = chain[QW][j].nq;
  end

  roc_interval u_interval (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (v_r[QW-1]),
    .q         (quo),
    .side      (s_r[QW-1]),
    .out_vld   (out_valid),
    .out_hit   (out_hit),
    .out_enter (out_t_enter),
    .out_exit  (out_t_exit)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_enter == '0 && out_t_exit == '0)
    else $error("miss with nonzero distance");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_t_enter <= out_t_exit)
    else $error("entry beyond exit on hit");

  a_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
endmodule

/* rtl/roc_proj.sv */
// ----------------------------------------------------------------------------
// roc_proj
// Projection front end: offset, axis products, sums, slab numerators.
// ----------------------------------------------------------------------------
module roc_proj (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  logic signed [roc_pkg::COORD_W-1:0] org [3],
  input  logic signed [roc_pkg::COORD_W-1:0] dir [3],
  input  roc_pkg::box_cfg_t                cfg,
  output logic                             vld,
  output roc_pkg::div_t                    div_o [6],
  output roc_pkg::side_t                   side_o
);
  import roc_pkg::*;

  logic [3:0] v_r;
  logic signed [TOC_W-1:0]   toc_r [3];
  logic signed [COORD_W-1:0] dir_r [3];
  logic signed [E_W-1:0]     pe_r [3][3];
  logic signed [F_W-1:0]     pf_r [3][3];
  logic signed [E_W-1:0]     e_r [3];
  logic signed [F_W-1:0]     f_r [3];
  div_t  div_r [6];
  side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[2:0], acc};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      toc_r[k] <= TOC_W'($signed(cfg.center[k*COORD_W +: COORD_W])) - TOC_W'(org[k]);
      dir_r[k] <= dir[k];
    end
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        pe_r[a][k] <= E_W'($signed(cfg.axis[a][k*AXIS_W +: AXIS_W])) * E_W'(toc_r[k]);
        pf_r[a][k] <= F_W'($signed(cfg.axis[a][k*AXIS_W +: AXIS_W])) * F_W'(dir_r[k]);
      end
      e_r[a] <= pe_r[a][0] + pe_r[a][1] + pe_r[a][2];
      f_r[a] <= pf_r[a][0] + pf_r[a][1] + pf_r[a][2];
    end
  end

  always_ff @(posedge clk) begin : numerators
    logic signed [NUM_W-1:0] h, e, n1, n2;
    for (int a = 0; a < 3; a++) begin
      h  = NUM_W'({cfg.half[a*COORD_W +: COORD_W], {HALF_SH{1'b0}}});
      e  = NUM_W'(e_r[a]);
      n1 = e + h;
      n2 = e - h;
      div_r[2*a].rem   <= '0;
      div_r[2*a].nq    <= {(n1 < 0) ? -n1 : n1, {FRAC_SH{1'b0}}};
      div_r[2*a].d     <= (f_r[a] < 0) ? -f_r[a] : f_r[a];
      div_r[2*a+1].rem <= '0;
      div_r[2*a+1].nq  <= {(n2 < 0) ? -n2 : n2, {FRAC_SH{1'b0}}};
      div_r[2*a+1].d   <= (f_r[a] < 0) ? -f_r[a] : f_r[a];
      side_r.par[a]    <= (f_r[a] <= F_W'(PAR_EPS)) && (f_r[a] >= -F_W'(PAR_EPS));
      side_r.pmiss[a]  <= (e > h) || (e < -h);
      side_r.neg1[a]   <= (n1 < 0) != (f_r[a] < 0);
      side_r.neg2[a]   <= (n2 < 0) != (f_r[a] < 0);
    end
  end

  assign vld    = v_r[3];
  assign div_o  = div_r;
  assign side_o = side_r;
endmodule

/* rtl/roc_div_cell.sv */
// ----------------------------------------------------------------------------
// roc_div_cell
// One restoring divide step: shifts in a numerator bit, emits a quotient bit.
// ----------------------------------------------------------------------------
module roc_div_cell (
  input  logic          clk,
  input  roc_pkg::div_t din,
  output roc_pkg::div_t dout
);
  import roc_pkg::*;

  logic [DEN_W:0] t;
  logic           ge;

  assign t  = {din.rem, din.nq[QW-1]};
  assign ge = t >= {1'b0, din.d};

  always_ff @(posedge clk) begin
    dout.rem <= ge ? DEN_W'(t - {1'b0, din.d}) : t[DEN_W-1:0];
    dout.nq  <= {din.nq[QW-2:0], ge};
    dout.d   <= din.d;
  end
endmodule

/* rtl/roc_interval.sv */
// ----------------------------------------------------------------------------
// roc_interval
// Signs and orders slab distances, narrows the interval, saturates results.
// ----------------------------------------------------------------------------
module roc_interval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld,
  input  logic [roc_pkg::QW-1:0]     q [6],
  input  roc_pkg::side_t             side,
  output logic                       out_vld,
  output logic                       out_hit,
  output logic [roc_pkg::DIST_W-1:0] out_enter,
  output logic [roc_pkg::DIST_W-1:0] out_exit
);
  import roc_pkg::*;

  localparam logic signed [T_W-1:0] TOP = T_W'({DIST_W{1'b1}});

  logic [1:0] v_r;
  logic signed [T_W-1:0] lo_r [3];
  logic signed [T_W-1:0] hi_r [3];
  side_t s_r;
  logic signed [T_W-1:0] tmin_r, tmax_r;
  logic bnd_r, pm_r;
  logic hit_r;
  logic [DIST_W-1:0] en_r, ex_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[0], vld};
  end

  always_ff @(posedge clk) begin : order
    logic signed [T_W-1:0] t1, t2;
    for (int a = 0; a < 3; a++) begin
      t1 = side.neg1[a] ? -$signed({1'b0, q[2*a]})   : $signed({1'b0, q[2*a]});
      t2 = side.neg2[a] ? -$signed({1'b0, q[2*a+1]}) : $signed({1'b0, q[2*a+1]});
      lo_r[a] <= (t1 > t2) ? t2 : t1;
      hi_r[a] <= (t1 > t2) ? t1 : t2;
    end
    s_r <= side;
  end

  always_ff @(posedge clk) begin : narrow
    logic signed [T_W-1:0] mn, mx;
    logic b;
    mn = '0;
    mx = '0;
    b  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!s_r.par[a]) begin
        if (lo_r[a] > mn) mn = lo_r[a];
        if (!b || hi_r[a] < mx) mx = hi_r[a];
        b = 1'b1;
      end
    end
    tmin_r <= mn;
    tmax_r <= mx;
    bnd_r  <= b;
    pm_r   <= |(s_r.par & s_r.pmiss);
  end

  always_ff @(posedge clk) begin : finish
    logic miss;
    miss  = pm_r || (bnd_r && (tmin_r > tmax_r || tmax_r < 0));
    hit_r <= !miss;
    if (miss) begin
      en_r <= '0;
      ex_r <= '0;
    end else begin
      en_r <= (tmin_r >= TOP) ? '1 : tmin_r[DIST_W-1:0];
      if (!bnd_r || tmax_r >= TOP) ex_r <= '1;
      else                         ex_r <= tmax_r[DIST_W-1:0];
    end
  end

  logic o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) o_r <= 1'b0;
    else        o_r <= v_r[1];
  end

  assign out_vld   = o_r;
  assign out_hit   = hit_r;
  assign out_enter = en_r;
  assign out_exit  = ex_r;
endmodule
